### src/fpa_pkg.sv
package fpa_pkg;

    localparam int DivBits = 32;
    localparam int AngBits = 16;
    localparam int PolySteps = 7;

    localparam logic [31:0] PolyInit = 32'h0000_00A9;
    localparam logic [15:0] AngHalf = 16'h8000;
    localparam logic [15:0] AngQuarter = 16'h4000;
    localparam logic [15:0] AngThreeQ = 16'hC000;

    // Side information that travels with each transaction through the pipe.
    typedef struct packed {
        logic       neg;      // quotient must be negated
        logic       swap;     // |y| > |x|: result is quarter turn minus atan
        logic       half;     // add a half turn
        logic       fixed;    // axis case, angle is given by fix_ang
        logic [15:0] fix_ang;
    } t_side;

    function automatic logic [31:0] poly_coef(input logic [2:0] idx);
        logic [31:0] c;
        begin
            case (idx)
                3'd0: c = 32'h0000_0390;
                3'd1: c = 32'h0000_091C;
                3'd2: c = 32'h0000_0FB6;
                3'd3: c = 32'h0000_16AA;
                3'd4: c = 32'h0000_2081;
                3'd5: c = 32'h0000_3651;
                3'd6: c = 32'h0000_A2F9;
                default: c = 32'h0000_0000;
            endcase
            return c;
        end
    endfunction

endpackage

### src/fixed_point_atan2_unit.sv
// Throughput: one transaction per cycle; 32 divide cells, one bit each, and 7 two-stage
// polynomial cells form one pipeline that advances whenever its output slot is free.
// A stalled output stops the whole pipe; o_s_tready is low only then.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module fixed_point_atan2_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] x_coord, [63:32] y_coord
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] angle
);
    localparam int N = fpa_pkg::DivBits;
    localparam int P = fpa_pkg::PolySteps;

    logic w_en;
    assign w_en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // Stage 0: classify and form operands.
    logic [31:0] w_x, w_y, w_ax, w_ay, w_num, w_den, w_ny, w_nx;
    fpa_pkg::t_side w_side;
    assign w_x = i_s_tdata[31:0];
    assign w_y = i_s_tdata[63:32];
    assign w_ax = w_x[31] ? (32'd0 - w_x) : w_x;
    assign w_ay = w_y[31] ? (32'd0 - w_y) : w_y;
    assign w_ny = {w_y[17:0], 14'd0};
    assign w_nx = {w_x[17:0], 14'd0};

    always_comb begin
        w_side = '0;
        if (w_y == 32'd0) begin
            w_side.fixed = 1'b1;
            w_side.fix_ang = w_x[31] ? fpa_pkg::AngHalf : 16'd0;
        end else if (w_x == 32'd0) begin
            w_side.fixed = 1'b1;
            w_side.fix_ang = w_y[31] ? fpa_pkg::AngThreeQ : fpa_pkg::AngQuarter;
        end
        if (w_ax >= w_ay) begin
            w_num = w_ny[31] ? (32'd0 - w_ny) : w_ny;
            w_den = w_ax;
            w_side.neg = w_ny[31] ^ w_x[31];
            w_side.half = w_x[31];
        end else begin
            w_num = w_nx[31] ? (32'd0 - w_nx) : w_nx;
            w_den = w_ay;
            w_side.neg = w_nx[31] ^ w_y[31];
            w_side.half = w_y[31];
            w_side.swap = 1'b1;
        end
        if (w_side.fixed) w_den = 32'd1;
    end

    logic [N:0] r_vld;
    logic [31:0] r_rem [0:N];
    logic [31:0] r_num [0:N];
    logic [31:0] r_den [0:N];
    fpa_pkg::t_side r_side [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0] <= 32'd0;
            r_num[0] <= w_num;
            r_den[0] <= w_den;
            r_side[0] <= w_side;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_div
        fpa_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(r_vld[g]), .i_rem(r_rem[g]), .i_num(r_num[g]),
            .i_den(r_den[g]), .i_side(r_side[g]),
            .o_vld(r_vld[g+1]), .o_rem(r_rem[g+1]), .o_num(r_num[g+1]),
            .o_den(r_den[g+1]), .o_side(r_side[g+1])
        );
    end

    // Signed quotient t, then t*t, then s = -(t*t >>> 14).
    logic        r_tv, r_sv;
    logic [31:0] r_t1, r_tt, r_t2, w_s;
    fpa_pkg::t_side r_sd1, r_sd2;
    logic [31:0] w_tt;
    logic signed [31:0] w_tt_sh;
    assign w_tt = r_t1 * r_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_en) begin
            r_tv <= r_vld[N];
            r_sv <= r_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1 <= r_side[N].neg ? (32'd0 - r_num[N]) : r_num[N];
            r_sd1 <= r_side[N];
            r_tt <= w_tt;
            r_t2 <= r_t1;
            r_sd2 <= r_sd1;
        end
    end

    assign w_tt_sh = $signed(r_tt) >>> 14;
    assign w_s = 32'd0 - w_tt_sh;

    logic [P:0] r_pv;
    logic [31:0] r_p [0:P];
    logic [31:0] r_ps [0:P];
    logic [31:0] r_pt [0:P];
    fpa_pkg::t_side r_psd [0:P];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else if (w_en) begin
            r_pv[0] <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= fpa_pkg::PolyInit;
            r_ps[0] <= w_s;
            r_pt[0] <= r_t2;
            r_psd[0] <= r_sd2;
        end
    end

    for (genvar k = 0; k < P; k++) begin : g_poly
        fpa_poly_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_idx(3'(k)),
            .i_vld(r_pv[k]), .i_p(r_p[k]), .i_s(r_ps[k]), .i_t(r_pt[k]),
            .i_side(r_psd[k]),
            .o_vld(r_pv[k+1]), .o_p(r_p[k+1]), .o_s(r_ps[k+1]), .o_t(r_pt[k+1]),
            .o_side(r_psd[k+1])
        );
    end

    // Final product p*t, then octant and quadrant correction.
    logic        r_fv;
    logic [31:0] r_pf;
    fpa_pkg::t_side r_fsd;
    logic [31:0] w_pf;
    logic [15:0] w_at, n_ang;
    assign w_pf = r_p[P] * r_pt[P];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            o_m_tvalid <= 1'b0;
        end else if (w_en) begin
            r_fv <= r_pv[P];
            o_m_tvalid <= r_fv;
        end
    end

    always_comb begin
        w_at = r_pf[31:16];
        n_ang = r_fsd.swap ? (fpa_pkg::AngQuarter - w_at) : w_at;
        if (r_fsd.half) n_ang = n_ang + fpa_pkg::AngHalf;
        if (r_fsd.fixed) n_ang = r_fsd.fix_ang;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pf <= w_pf;
            r_fsd <= r_psd[P];
            o_m_tdata <= n_ang;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output slot");
    a_known_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !$isunknown(o_m_tdata))
        else $error("result data unknown while valid");
    a_div_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_vld[0] |=> r_vld[1])
        else $error("divide pipe lost a transaction");
endmodule

### src/fpa_div_cell.sv
// One restoring step of the unsigned divide: brings in one numerator bit.
module fpa_div_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [31:0] i_rem,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    input  fpa_pkg::t_side i_side,
    output logic        o_vld,
    output logic [31:0] o_rem,
    output logic [31:0] o_num,
    output logic [31:0] o_den,
    output fpa_pkg::t_side o_side
);
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_trial = {i_rem, i_num[31]};
    assign w_diff = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    // The numerator shifts left; its freed low bits collect quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_diff[32]) begin
                o_rem <= w_diff[31:0];
                o_num <= {i_num[30:0], 1'b1};
            end else begin
                o_rem <= w_trial[31:0];
                o_num <= {i_num[30:0], 1'b0};
            end
            o_den <= i_den;
            o_side <= i_side;
        end
    end
endmodule

### src/fpa_poly_cell.sv
// One Horner step, split over two registers: p*s, then shift and add c.
module fpa_poly_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [2:0]  i_idx,
    input  logic        i_vld,
    input  logic [31:0] i_p,
    input  logic [31:0] i_s,
    input  logic [31:0] i_t,
    input  fpa_pkg::t_side i_side,
    output logic        o_vld,
    output logic [31:0] o_p,
    output logic [31:0] o_s,
    output logic [31:0] o_t,
    output fpa_pkg::t_side o_side
);
    logic        r_vld;
    logic [31:0] r_prod;
    logic [31:0] r_s;
    logic [31:0] r_t;
    fpa_pkg::t_side r_side;
    logic [31:0] w_full;
    logic signed [31:0] w_shift;

    assign w_full = i_p * i_s;
    // The shift is kept in its own signed net so that it stays arithmetic.
    assign w_shift = $signed(r_prod) >>> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
            o_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full;
            r_s <= i_s;
            r_t <= i_t;
            r_side <= i_side;
            o_p <= w_shift + fpa_pkg::poly_coef(i_idx);
            o_s <= r_s;
            o_t <= r_t;
            o_side <= r_side;
        end
    end
endmodule

### dv/fixed_point_atan2_checker.sv
`timescale 1ns / 1ps

module fixed_point_atan2_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,    // [31:0] x_coord, [63:32] y_coord
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // [15:0] angle
    output int          o_fail_count,
    output int          o_pending,
    output int          o_angles_checked
);

    logic [15:0] angle_queue[$];

    function automatic logic [31:0] asr_product(input logic [31:0] a, input logic [31:0] b,
                                                input int sh);
        logic [31:0] prod;
        begin
            prod = a * b;
            return $unsigned($signed(prod) >>> sh);
        end
    endfunction

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] signed_quotient(input logic [31:0] num,
                                                    input logic [31:0] den);
        logic [31:0] q;
        begin
            q = magnitude(num) / magnitude(den);
            return (num[31] ^ den[31]) ? (32'd0 - q) : q;
        end
    endfunction

    function automatic logic [31:0] series_atan(input logic [31:0] t);
        logic [31:0] sq;
        logic [31:0] p;
        logic [31:0] coef[7];
        begin
            coef = '{32'h390, 32'h91C, 32'hFB6, 32'h16AA, 32'h2081, 32'h3651, 32'hA2F9};
            sq = 32'd0 - asr_product(t, t, 14);
            p = fpa_pkg::PolyInit;
            for (int i = 0; i < fpa_pkg::PolySteps; i++) begin
                p = asr_product(p, sq, 14) + coef[i];
            end
            return asr_product(p, t, 16);
        end
    endfunction

    function automatic logic [15:0] predict_angle(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] ang;
        begin
            if (y == 0) begin
                ang = x[31] ? 32'(fpa_pkg::AngHalf) : 32'd0;
            end else if (x == 0) begin
                ang = y[31] ? 32'(fpa_pkg::AngThreeQ) : 32'(fpa_pkg::AngQuarter);
            end else if (magnitude(x) >= magnitude(y)) begin
                ang = series_atan(signed_quotient(y << 14, x));
                if (x[31]) ang = ang + 32'(fpa_pkg::AngHalf);
            end else begin
                ang = 32'(fpa_pkg::AngQuarter) - series_atan(signed_quotient(x << 14, y));
                if (y[31]) ang = ang + 32'(fpa_pkg::AngHalf);
            end
            return ang[15:0];
        end
    endfunction

    assign o_pending = angle_queue.size();

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            angle_queue.delete();
            o_fail_count <= 0;
            o_angles_checked <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                angle_queue.push_back(predict_angle(i_s_tdata[31:0], i_s_tdata[63:32]));
            end
            if (i_m_tvalid && i_m_tready) begin
                o_angles_checked <= o_angles_checked + 1;
                if (angle_queue.size() == 0) begin
                    $display("%0t: unexpected angle, expected none, actual %h", $time,
                             i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = angle_queue.pop_front();
                    if (want !== i_m_tdata) begin
                        $display("%0t: angle mismatch, expected %h, actual %h", $time,
                                 want, i_m_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/tb_fixed_point_atan2_unit.sv
`timescale 1ns / 1ps

module tb_fixed_point_atan2_unit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;       // [31:0] x_coord, [63:32] y_coord
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] angle
    int          fail_count;
    int          pending;
    int          angles_checked;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int          quiet_cycles = 0;
    int          points_sent = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    fixed_point_atan2_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    fixed_point_atan2_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_angles_checked(angles_checked)
    );

    // Receiver: random stalls, or a long hold-off while the sender keeps pushing.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 5000 && !hold_off) begin
                $display("TB_ERROR");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(2000) - 1000;
            4: return $urandom & 32'h0001_FFFF;
            5: return -($urandom & 32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // Offers one point, inserting idle cycles by the current rate, and waits for acceptance.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        points_sent++;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_point(pick_coord(), pick_coord());
    endtask

    initial begin
        logic [31:0] edge_vals[8];
        edge_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF,
                      32'd100, 32'hFFFF_FF9C, 32'h0002_0000};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Axes, diagonal, both operand orders and the most negative value.
        send_point(32'd5, 32'd0);
        send_point(32'hFFFF_FFFB, 32'd0);
        send_point(32'd0, 32'd0);
        send_point(32'd0, 32'd7);
        send_point(32'd0, 32'hFFFF_FFF9);
        send_point(32'd1000, 32'd1000);
        send_point(32'hFFFF_FC18, 32'd1000);
        send_point(32'd3, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        for (int i = 0; i < 16; i++) send_point(edge_vals[i % 8], edge_vals[(i * 3 + 1) % 8]);
        run_phase(0, 0, 450);
        run_phase(80, 0, 300);
        run_phase(0, 80, 300);
        run_phase(26, 26, 450);
        // Long receiver hold-off so the pipe fills and backpressures the input.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            run_phase(0, 0, 300);
        join
        s_tvalid <= 1'b0;
        begin : drain
            int waited;
            waited = 0;
            while (pending != 0 && waited < 20000) begin
                @(posedge i_clk);
                waited++;
            end
            repeat (60) @(posedge i_clk);
            $display("Sent %0d points (axes, extremes, random) and checked %0d angles", points_sent,
                     angles_checked);
            $display("across idle, sender-gap, receiver-stall, mixed and hold-off phases.");
            if (fail_count == 0 && pending == 0) begin
                $display("TB_OK");
            end else begin
                $display("TB_ERROR");
            end
            $finish;
        end
    end

endmodule
